>>> rtl/core/mpeg_audio_frame_checker_unit_defines.svh
// Assertion macros used by the frame checker front end.
`ifndef MPEG_AUDIO_FRAME_CHECKER_UNIT_DEFINES_SVH
`define MPEG_AUDIO_FRAME_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MAF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MAF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/maf_pkg.sv
// Package: types, status codes and rate tables of the MPEG audio frame checker.
package maf_pkg;

    localparam logic [3:0] ST_FRAME       = 4'd0;
    localparam logic [3:0] ST_OK          = 4'd1;
    localparam logic [3:0] ST_SYNC        = 4'd2;
    localparam logic [3:0] ST_VERSION     = 4'd3;
    localparam logic [3:0] ST_LAYER       = 4'd4;
    localparam logic [3:0] ST_BITRATE     = 4'd5;
    localparam logic [3:0] ST_RATE        = 4'd6;
    localparam logic [3:0] ST_FREE        = 4'd7;
    localparam logic [3:0] ST_MIS_VERSION = 4'd8;
    localparam logic [3:0] ST_MIS_LAYER   = 4'd9;
    localparam logic [3:0] ST_MIS_RATE    = 4'd10;
    localparam logic [3:0] ST_MIS_CHAN    = 4'd11;
    localparam logic [3:0] ST_TRUNC       = 4'd12;

    localparam logic [1:0] VER_MPEG1    = 2'd3;
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] LAY_I        = 2'd3;
    localparam logic [1:0] LAY_II       = 2'd2;
    localparam logic [1:0] LAY_III      = 2'd1;
    localparam logic [1:0] LAY_RESERVED = 2'd0;
    localparam logic [1:0] RIX_RESERVED = 2'd3;
    localparam logic [1:0] CHM_MONO     = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_W       = 27;
    localparam int DIV_CNT_W   = 5;
    localparam logic [17:0] FACTOR_LAY_I   = 18'd12000;
    localparam logic [17:0] FACTOR_HALF    = 18'd72000;
    localparam logic [17:0] FACTOR_FULL    = 18'd144000;
    localparam logic [11:0] LEN_MAX        = 12'd4095;

    // bitrates in kbit/s by table row and index
    localparam logic [8:0] KBPS_TAB [5][16] = '{
        '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
          9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
        '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
          9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } maf_in_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        final_res;
        logic [1:0]  version_id;
        logic [1:0]  layer_code;
        logic [3:0]  bitrate_index;
        logic [1:0]  rate_index;
        logic        padding;
        logic [1:0]  channel_mode;
        logic [11:0] payload_length;
    } maf_out_t;

    // one classified event passed from front to back
    typedef struct packed {
        logic [3:0] status;
        logic       final_res;
        logic       need_len;
        logic [1:0] version_id;
        logic [1:0] layer_code;
        logic [3:0] bitrate_index;
        logic [1:0] rate_index;
        logic       padding;
        logic [1:0] channel_mode;
    } maf_job_t;

    // payload length returned to the front
    typedef struct packed {
        logic        valid;
        logic [11:0] len;
    } maf_fb_t;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_ERROR,
        PH_WAIT
    } maf_phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_FIN
    } maf_back_state_t;

    function automatic logic [8:0] kbps_of(input logic [1:0] ver, input logic [1:0] lay,
                                           input logic [3:0] bri);
        logic [2:0] row;
        logic       ok;
        row = 3'd0;
        ok  = 1'b1;
        if (ver == VER_MPEG1) begin
            case (lay)
                LAY_I:   row = 3'd0;
                LAY_II:  row = 3'd1;
                LAY_III: row = 3'd2;
                default: ok = 1'b0;
            endcase
        end else if (ver != VER_RESERVED) begin
            case (lay)
                LAY_I:   row = 3'd3;
                LAY_II:  row = 3'd4;
                LAY_III: row = 3'd4;
                default: ok = 1'b0;
            endcase
        end else begin
            ok = 1'b0;
        end
        return ok ? KBPS_TAB[row][bri] : 9'd0;
    endfunction

    function automatic logic [15:0] srate_of(input logic [1:0] ver, input logic [1:0] rix);
        logic [15:0] base;
        case (rix)
            2'd0:    base = 16'd44100;
            2'd1:    base = 16'd48000;
            2'd2:    base = 16'd32000;
            default: base = 16'd0;
        endcase
        case (ver)
            VER_MPEG1: return base;
            2'd2:      return base >> 1;
            2'd0:      return base >> 2;
            default:   return 16'd0;
        endcase
    endfunction

endpackage

>>> rtl/core/mpeg_audio_frame_checker_unit.sv
// MPEG audio frame checker: one word per cycle while input is not stalled by a full queue.
// A good header that is not the last word stalls input until the back end returns its length
// (queue pop, one multiply, 27 divide steps, a finish state that waits for a free result slot).
// A result passes through the queue and then the result register; a length also passes the divider.
// Reset (rst_n low, asynchronous) clears phase, counters, references and kept error.
module mpeg_audio_frame_checker_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              data_valid,
    output logic              data_ready,
    input  maf_pkg::maf_in_t  data,
    output logic              result_valid,
    input  logic              result_ready,
    output maf_pkg::maf_out_t result
);
    import maf_pkg::*;

    logic     q_push, q_pop, q_empty, q_full;
    maf_job_t q_job, q_head;
    maf_fb_t  fb;

    maf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data       (data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (q_job),
        .fb         (fb)
    );

    maf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    maf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .fb           (fb),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> rtl/core/maf_front.sv
// Front end: gathers header bytes, checks them and tracks payload skipping.
`include "mpeg_audio_frame_checker_unit_defines.svh"

module maf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             data_valid,
    output logic             data_ready,
    input  maf_pkg::maf_in_t data,
    input  logic             q_full,
    output logic             q_push,
    output maf_pkg::maf_job_t q_job,
    input  maf_pkg::maf_fb_t fb
);
    import maf_pkg::*;

    maf_phase_t  phase_reg, phase_next;
    logic [23:0] shift_reg, shift_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [11:0] left_reg, left_next;
    logic        refv_reg, refv_next;
    logic [1:0]  refver_reg, refver_next;
    logic [1:0]  reflay_reg, reflay_next;
    logic [1:0]  refrix_reg, refrix_next;
    logic        refmono_reg, refmono_next;
    logic [3:0]  kept_reg, kept_next;

    logic [31:0] h;
    logic [1:0]  ver, lay, rix, chm;
    logic [3:0]  bri;
    logic        pad, mono, accept;
    logic [3:0]  err;

    assign data_ready = (phase_reg != PH_WAIT) && !q_full;
    assign accept     = data_valid && data_ready;

    // split the header and classify it
    assign h    = {shift_reg, data.data_byte};
    assign ver  = h[20:19];
    assign lay  = h[18:17];
    assign bri  = h[15:12];
    assign rix  = h[11:10];
    assign pad  = h[9];
    assign chm  = h[7:6];
    assign mono = (chm == CHM_MONO);

    always_comb
    begin
        if (h[31:21] != 11'h7FF)                  err = ST_SYNC;
        else if (ver == VER_RESERVED)             err = ST_VERSION;
        else if (lay == LAY_RESERVED)             err = ST_LAYER;
        else if (bri == 4'hF)                     err = ST_BITRATE;
        else if (rix == RIX_RESERVED)             err = ST_RATE;
        else if (refv_reg && refver_reg != ver)   err = ST_MIS_VERSION;
        else if (refv_reg && reflay_reg != lay)   err = ST_MIS_LAYER;
        else if (refv_reg && refrix_reg != rix)   err = ST_MIS_RATE;
        else if (refv_reg && refmono_reg != mono) err = ST_MIS_CHAN;
        else if (bri == 4'h0)                     err = ST_FREE;
        else                                      err = ST_FRAME;
    end

    // next state and queue push
    always_comb
    begin
        phase_next   = phase_reg;
        shift_next   = shift_reg;
        cnt_next     = cnt_reg;
        left_next    = left_reg;
        refv_next    = refv_reg;
        refver_next  = refver_reg;
        reflay_next  = reflay_reg;
        refrix_next  = refrix_reg;
        refmono_next = refmono_reg;
        kept_next    = kept_reg;
        q_push       = 1'b0;
        q_job        = '0;

        if (phase_reg == PH_WAIT && fb.valid) begin
            left_next  = fb.len;
            phase_next = (fb.len != 12'd0) ? PH_SKIP : PH_HEADER;
        end

        if (accept) begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (cnt_reg != 2'd3) begin
                        shift_next = {shift_reg[15:0], data.data_byte};
                        cnt_next   = cnt_reg + 2'd1;
                    end else begin
                        shift_next          = '0;
                        cnt_next            = 2'd0;
                        q_push              = 1'b1;
                        q_job.status        = err;
                        q_job.version_id    = ver;
                        q_job.layer_code    = lay;
                        q_job.bitrate_index = bri;
                        q_job.rate_index    = rix;
                        q_job.padding       = pad;
                        q_job.channel_mode  = chm;
                        if (err != ST_FRAME) begin
                            kept_next  = err;
                            phase_next = PH_ERROR;
                        end else begin
                            q_job.need_len = 1'b1;
                            phase_next     = PH_WAIT;
                            if (!refv_reg) begin
                                refv_next    = 1'b1;
                                refver_next  = ver;
                                reflay_next  = lay;
                                refrix_next  = rix;
                                refmono_next = mono;
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                    left_next = (left_reg != 12'd0) ? left_reg - 12'd1 : 12'd0;
                    if (left_next == 12'd0) phase_next = PH_HEADER;
                end
                default:
                begin
                end
            endcase

            // close the stream and return to reset state
            if (data.is_last) begin
                q_push          = 1'b1;
                q_job.final_res = 1'b1;
                if (kept_next != ST_FRAME)
                    q_job.status = kept_next;
                else if (q_job.need_len)
                    q_job.status = ST_FRAME;
                else if (phase_next == PH_HEADER && cnt_next == 2'd0)
                    q_job.status = ST_OK;
                else
                    q_job.status = ST_TRUNC;
                phase_next   = PH_HEADER;
                shift_next   = '0;
                cnt_next     = 2'd0;
                left_next    = '0;
                refv_next    = 1'b0;
                refver_next  = '0;
                reflay_next  = '0;
                refrix_next  = '0;
                refmono_next = 1'b0;
                kept_next    = ST_FRAME;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_HEADER;
            shift_reg   <= '0;
            cnt_reg     <= '0;
            left_reg    <= '0;
            refv_reg    <= 1'b0;
            refver_reg  <= '0;
            reflay_reg  <= '0;
            refrix_reg  <= '0;
            refmono_reg <= 1'b0;
            kept_reg    <= ST_FRAME;
        end else begin
            phase_reg   <= phase_next;
            shift_reg   <= shift_next;
            cnt_reg     <= cnt_next;
            left_reg    <= left_next;
            refv_reg    <= refv_next;
            refver_reg  <= refver_next;
            reflay_reg  <= reflay_next;
            refrix_reg  <= refrix_next;
            refmono_reg <= refmono_next;
            kept_reg    <= kept_next;
        end
    end

    `MAF_ASSERT_NOW(a_fb_only_when_waiting, fb.valid, phase_reg == PH_WAIT, "length returned while not waiting")
    `MAF_ASSERT_NOW(a_no_push_when_full, q_push, !q_full, "queue overrun")
    `MAF_ASSERT_NOW(a_error_kept, phase_reg == PH_ERROR, kept_reg != ST_FRAME, "error phase without kept code")

endmodule

>>> rtl/core/maf_queue.sv
// Short queue of classified events between front and back.
module maf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  maf_pkg::maf_job_t push_job,
    input  logic              pop,
    output maf_pkg::maf_job_t head,
    output logic              empty,
    output logic              full
);
    import maf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    maf_job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_reg, rd_reg;
    logic [PTR_W:0]       cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head  = mem_reg[rd_reg];

    // store entry
    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_job;
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

endmodule

>>> rtl/core/maf_back.sv
// Back end: payload length by multiply and bit-serial divide, result register.
module maf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  maf_pkg::maf_job_t  q_head,
    output logic               q_pop,
    output maf_pkg::maf_fb_t   fb,
    output logic               result_valid,
    input  logic               result_ready,
    output maf_pkg::maf_out_t  result
);
    import maf_pkg::*;

    maf_back_state_t        state_reg, state_next;
    maf_job_t               job_reg, job_next;
    logic [8:0]             kbps_reg, kbps_next;
    logic [17:0]            factor_reg, factor_next;
    logic [15:0]            sr_reg, sr_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [15:0]            rem_reg, rem_next;
    logic [NUM_W-1:0]       quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   rv_reg, rv_next;
    maf_out_t               res_reg, res_next;

    logic        out_free;
    logic [16:0] rem_sh;
    logic        fit;
    logic [29:0] len_full;
    logic [11:0] len;
    logic [26:0] product;

    assign out_free     = !rv_reg || result_ready;
    assign result_valid = rv_reg;
    assign result       = res_reg;

    // one divide step and the final length
    assign product  = 27'(kbps_reg * factor_reg);
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign fit      = rem_sh >= {1'b0, sr_reg};
    assign len_full = (job_reg.layer_code == LAY_I)
                    ? {(28'(quo_reg) + 28'(job_reg.padding)), 2'b00}
                    : 30'(28'(quo_reg) + 28'(job_reg.padding));
    assign len      = (len_full < 30'd4) ? 12'd0
                    : ((len_full - 30'd4) > 30'(LEN_MAX)) ? LEN_MAX
                    : 12'(len_full - 30'd4);

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        kbps_next   = kbps_reg;
        factor_next = factor_reg;
        sr_next     = sr_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        rv_next     = rv_reg && !result_ready;
        res_next    = res_reg;
        q_pop       = 1'b0;
        fb          = '0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty) begin
                    if (q_head.need_len) begin
                        q_pop       = 1'b1;
                        job_next    = q_head;
                        kbps_next   = kbps_of(q_head.version_id, q_head.layer_code,
                                              q_head.bitrate_index);
                        sr_next     = srate_of(q_head.version_id, q_head.rate_index);
                        if (q_head.layer_code == LAY_I)
                            factor_next = FACTOR_LAY_I;
                        else if (q_head.layer_code == LAY_III && q_head.version_id != VER_MPEG1)
                            factor_next = FACTOR_HALF;
                        else
                            factor_next = FACTOR_FULL;
                        state_next  = BK_MUL;
                    end else if (out_free) begin
                        q_pop                   = 1'b1;
                        rv_next                 = 1'b1;
                        res_next.status         = q_head.status;
                        res_next.final_res      = q_head.final_res;
                        res_next.version_id     = q_head.version_id;
                        res_next.layer_code     = q_head.layer_code;
                        res_next.bitrate_index  = q_head.bitrate_index;
                        res_next.rate_index     = q_head.rate_index;
                        res_next.padding        = q_head.padding;
                        res_next.channel_mode   = q_head.channel_mode;
                        res_next.payload_length = '0;
                    end
                end
            end
            BK_MUL:
            begin
                num_next   = product;
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = DIV_CNT_W'(NUM_W - 1);
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                rem_next = fit ? 16'(rem_sh - {1'b0, sr_reg}) : rem_sh[15:0];
                quo_next = {quo_reg[NUM_W-2:0], fit};
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) state_next = BK_FIN;
            end
            BK_FIN:
            begin
                if (out_free) begin
                    rv_next                 = 1'b1;
                    res_next.final_res      = job_reg.final_res;
                    res_next.version_id     = job_reg.version_id;
                    res_next.layer_code     = job_reg.layer_code;
                    res_next.bitrate_index  = job_reg.bitrate_index;
                    res_next.rate_index     = job_reg.rate_index;
                    res_next.padding        = job_reg.padding;
                    res_next.channel_mode   = job_reg.channel_mode;
                    res_next.payload_length = len;
                    if (job_reg.final_res)
                        res_next.status = (len == 12'd0) ? ST_OK : ST_TRUNC;
                    else
                        res_next.status = ST_FRAME;
                    fb.valid   = !job_reg.final_res;
                    fb.len     = len;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        kbps_reg   <= kbps_next;
        factor_reg <= factor_next;
        sr_reg     <= sr_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= BK_IDLE;
            rv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

endmodule
